// ===== src/dars_pkg.sv =====
// Shared types and codes for the disk arm request scheduler.
// Item structs for both channels, op/status/register codes, default geometry.
`timescale 1ns / 1ps

package dars_pkg;

    localparam int QUEUE_DEPTH_DEF       = 16;
    localparam int SECTORS_PER_TRACK_DEF = 16;
    localparam int CFG_DATA_W            = 16;
    localparam int CFG_IDX_W             = 2;

    // op codes
    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_PICK = 2'd1;
    localparam logic [1:0] OP_ARM  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // request direction
    localparam logic DIR_READ  = 1'b0;
    localparam logic DIR_WRITE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLATTER_COUNT = 2'd2;

    localparam logic        MODE_FCFS           = 1'b0;
    localparam logic        MODE_RST            = 1'b1;
    localparam logic [15:0] TRACK_COUNT_RST     = 16'd256;
    localparam logic [7:0]  PLATTER_COUNT_RST   = 8'd1;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  tag;
        logic [15:0] track;
        logic [7:0]  first_sector;
        logic [15:0] sector_count;
        logic [7:0]  platter;
        logic        is_write;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_tag;
        logic [15:0] out_track;
        logic [7:0]  out_first_sector;
        logic [15:0] out_sector_count;
        logic [7:0]  out_platter;
        logic        out_is_write;
        logic [15:0] arm_position;
    } t_out_item;

    // one queued request, 57 bits
    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] track;
        logic [7:0]  first_sector;
        logic [15:0] sector_count;
        logic [7:0]  platter;
        logic        is_write;
    } t_req;

endpackage

// ===== src/disk_arm_request_scheduler_top.sv =====
// Disk arm scheduler top: queue RAM, sequencer, one shared distance unit; uses dars_pkg.
// Enqueue, arm and invalid ops pass from accept through S_EXEC and S_DONE to result valid.
// Pick: S_EXEC, then S_SCAN reads entries through the RAM read port (1 in FCFS, N in SSTF),
// then S_SHIFT moves the entries behind picked slot k down one per cycle, then S_DONE.
// One item in flight; the next is accepted in the cycle after the result is registered.
// Reset (sync, active low) empties the queue, parks the arm at track 0, reloads registers.
`timescale 1ns / 1ps

module disk_arm_request_scheduler_top #(
    parameter int QUEUE_DEPTH       = dars_pkg::QUEUE_DEPTH_DEF,
    parameter int SECTORS_PER_TRACK = dars_pkg::SECTORS_PER_TRACK_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  dars_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output dars_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_we,
    input  logic [dars_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dars_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int SPT_W = $clog2(SECTORS_PER_TRACK + 1);
    localparam int SUM_W = 16 + SPT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state              r_state;
    dars_pkg::t_in_item  r_in;
    dars_pkg::t_out_item r_out;
    logic                r_out_valid;
    logic                r_mode;
    logic [15:0]         r_track_count;
    logic [7:0]          r_platter_count;
    logic [CNT_W-1:0]    r_count;
    logic [15:0]         r_arm;
    logic [1:0]          r_status;
    logic                r_picked;
    logic [CNT_W-1:0]    r_ptr;
    logic [CNT_W-1:0]    r_last;
    logic                r_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx;
    dars_pkg::t_req      r_best;
    logic [IDX_W-1:0]    r_best_idx;
    logic [15:0]         r_best_dist;

    dars_pkg::t_req      mem [QUEUE_DEPTH];
    dars_pkg::t_req      r_mem_rd;
    logic [IDX_W-1:0]    mem_ra;
    logic [IDX_W-1:0]    mem_wa;
    logic                mem_we;
    dars_pkg::t_req      mem_wd;

    logic [SUM_W-1:0]    last_end;
    logic [SUM_W-1:0]    limit;
    logic                req_ok;
    logic                full;
    logic [15:0]         seek_d;
    logic                same_spot;
    logic                take;
    logic [IDX_W-1:0]    scan_k;
    dars_pkg::t_req      in_req;
    dars_pkg::t_out_item n_out;

    // geometry check on the registered item
    always_comb begin
        last_end = SUM_W'(r_in.track) * SUM_W'(SECTORS_PER_TRACK)
                 + SUM_W'(r_in.first_sector) + SUM_W'(r_in.sector_count);
        limit    = SUM_W'(r_track_count) * SUM_W'(SECTORS_PER_TRACK);
        req_ok   = (r_in.platter < r_platter_count)
                && (r_in.track < r_track_count)
                && (9'(r_in.first_sector) < 9'(SECTORS_PER_TRACK))
                && (r_in.sector_count != 16'd0)
                && (last_end <= limit);
        full     = (r_count >= CNT_W'(QUEUE_DEPTH));
        in_req   = '{tag: r_in.tag, track: r_in.track, first_sector: r_in.first_sector,
                     sector_count: r_in.sector_count, platter: r_in.platter,
                     is_write: r_in.is_write};
    end

    // shared distance/compare unit, fed by the RAM read register
    always_comb begin
        seek_d = (r_mem_rd.track >= r_arm) ? (r_mem_rd.track - r_arm)
                                           : (r_arm - r_mem_rd.track);
        same_spot = (r_mem_rd.track == r_best.track)
                 && (r_mem_rd.first_sector == r_best.first_sector);
        take = (r_cmp_idx == '0) || (seek_d < r_best_dist)
            || ((seek_d == r_best_dist)
                && (!same_spot || (r_mem_rd.is_write == dars_pkg::DIR_WRITE
                                   && r_best.is_write != dars_pkg::DIR_WRITE)));
        scan_k = (r_cmp_vld && take) ? r_cmp_idx : r_best_idx;
    end

    // result item built from the pick state
    always_comb begin
        n_out              = '0;
        n_out.status       = r_status;
        n_out.arm_position = r_picked ? r_best.track : r_arm;
        if (r_picked) begin
            n_out.out_tag          = r_best.tag;
            n_out.out_track        = r_best.track;
            n_out.out_first_sector = r_best.first_sector;
            n_out.out_sector_count = r_best.sector_count;
            n_out.out_platter      = r_best.platter;
            n_out.out_is_write     = r_best.is_write;
        end
    end

    // RAM port control
    always_comb begin
        mem_ra = r_ptr[IDX_W-1:0];
        if (r_state == S_EXEC) begin
            mem_we = (r_in.op == dars_pkg::OP_ENQ) && req_ok && !full;
            mem_wa = r_count[IDX_W-1:0];
            mem_wd = in_req;
        end else begin
            mem_we = (r_state == S_SHIFT) && r_cmp_vld;
            mem_wa = r_cmp_idx;
            mem_wd = r_mem_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_mem_rd <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_mode          <= dars_pkg::MODE_RST;
            r_track_count   <= dars_pkg::TRACK_COUNT_RST;
            r_platter_count <= dars_pkg::PLATTER_COUNT_RST;
            r_count         <= '0;
            r_arm           <= '0;
            r_picked        <= 1'b0;
            r_cmp_vld       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dars_pkg::CFG_MODE:          r_mode          <= i_cfg_data[0];
                    dars_pkg::CFG_TRACK_COUNT:   r_track_count   <= i_cfg_data[15:0];
                    dars_pkg::CFG_PLATTER_COUNT: r_platter_count <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // S_DONE owns the valid flag while it hands over a result
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_item;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_cmp_vld <= 1'b0;
                    r_ptr     <= '0;
                    unique case (r_in.op)
                        dars_pkg::OP_ENQ: begin
                            r_picked <= 1'b0;
                            r_state  <= S_DONE;
                            if (!req_ok) begin
                                r_status <= dars_pkg::ST_INVALID;
                            end else if (full) begin
                                r_status <= dars_pkg::ST_FULL;
                            end else begin
                                r_status <= dars_pkg::ST_OK;
                                r_count  <= r_count + 1'b1;
                            end
                        end
                        dars_pkg::OP_PICK: begin
                            if (r_count == '0) begin
                                r_picked <= 1'b0;
                                r_status <= dars_pkg::ST_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_picked <= 1'b1;
                                r_status <= dars_pkg::ST_OK;
                                r_last   <= (r_mode == dars_pkg::MODE_FCFS) ? '0
                                                                            : r_count - 1'b1;
                                r_state  <= S_SCAN;
                            end
                        end
                        dars_pkg::OP_ARM: begin
                            r_picked <= 1'b0;
                            r_status <= dars_pkg::ST_OK;
                            r_arm    <= r_in.track;
                            r_state  <= S_DONE;
                        end
                        default: begin
                            r_picked <= 1'b0;
                            r_status <= dars_pkg::ST_INVALID;
                            r_state  <= S_DONE;
                        end
                    endcase
                end
                S_SCAN: begin
                    // read of entry r_ptr overlaps compare of entry r_cmp_idx
                    if (r_cmp_vld && take) begin
                        r_best      <= r_mem_rd;
                        r_best_idx  <= r_cmp_idx;
                        r_best_dist <= seek_d;
                    end
                    if (r_ptr <= r_last) begin
                        r_ptr     <= r_ptr + 1'b1;
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= r_ptr[IDX_W-1:0];
                    end else begin
                        r_cmp_vld <= 1'b0;
                        if (r_cmp_vld) begin
                            r_ptr   <= CNT_W'(scan_k) + 1'b1;
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    // close the gap: entry r_ptr moves to r_ptr-1
                    if (r_ptr < r_count) begin
                        r_ptr     <= r_ptr + 1'b1;
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= IDX_W'(r_ptr - 1'b1);
                    end else begin
                        r_cmp_vld <= 1'b0;
                        r_count   <= r_count - 1'b1;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out       <= n_out;
                        if (r_picked) begin
                            r_arm <= r_best.track;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SHIFT) |-> (r_count != '0))
        else $error("scan or shift on empty queue");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_cmp_vld) |-> ((CNT_W'(r_cmp_idx) + 1'b1) < r_count))
        else $error("shift writes past the queue tail");

    a_done_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside completion");

endmodule

// ===== tb/dars_sched_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the disk arm request scheduler: watches both item channels and
// the register port, keeps its own copy of queue, arm and geometry, compares results.
// Depends on dars_pkg for item structs, op/status codes and register indexes.

module dars_sched_checker #(
    parameter int QUEUE_DEPTH       = dars_pkg::QUEUE_DEPTH_DEF,
    parameter int SECTORS_PER_TRACK = dars_pkg::SECTORS_PER_TRACK_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  dars_pkg::t_in_item               i_in_item,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  dars_pkg::t_out_item              i_out_item,
    input  logic                             i_cfg_we,
    input  logic [dars_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dars_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_fail_count,
    output int                               o_outstanding,
    output int                               o_picked,
    output int                               o_refused,
    output int                               o_empty_picks
);

    dars_pkg::t_req      queued_reqs[$];
    dars_pkg::t_out_item due_results[$];
    logic [15:0]         arm_pos;
    logic                rule_mode;
    logic [15:0]         disk_tracks;
    logic [7:0]          disk_platters;
    dars_pkg::t_out_item want;
    bit                  bad;

    // geometry check, including the last sector of a multi-track run
    function automatic bit fits_disk(dars_pkg::t_req r);
        int run_end;
        if (r.platter >= disk_platters) return 1'b0;
        if (r.track >= disk_tracks) return 1'b0;
        if (r.first_sector >= SECTORS_PER_TRACK) return 1'b0;
        if (r.sector_count == 16'd0) return 1'b0;
        run_end = r.track * SECTORS_PER_TRACK + r.first_sector + r.sector_count;
        return run_end <= disk_tracks * SECTORS_PER_TRACK;
    endfunction

    function automatic logic [15:0] seek_dist(logic [15:0] t);
        return (t >= arm_pos) ? t - arm_pos : arm_pos - t;
    endfunction

    // SSTF: nearest track; equal distance and same target -> write over read,
    // any other equal distance -> the later entry
    function automatic int choose_slot();
        int          best;
        logic [15:0] best_d;
        logic [15:0] d;
        best = 0;
        if (rule_mode == dars_pkg::MODE_FCFS) return 0;
        best_d = seek_dist(queued_reqs[0].track);
        for (int i = 1; i < queued_reqs.size(); i++) begin
            d = seek_dist(queued_reqs[i].track);
            if (d < best_d) begin
                best_d = d;
                best   = i;
            end else if (d == best_d) begin
                if (queued_reqs[i].track == queued_reqs[best].track &&
                    queued_reqs[i].first_sector == queued_reqs[best].first_sector) begin
                    if (queued_reqs[i].is_write == dars_pkg::DIR_WRITE &&
                        queued_reqs[best].is_write != dars_pkg::DIR_WRITE)
                        best = i;
                end else begin
                    best = i;
                end
            end
        end
        return best;
    endfunction

    // advances the predicted state by one item and returns its result
    function automatic dars_pkg::t_out_item apply_item(dars_pkg::t_in_item it);
        dars_pkg::t_out_item res;
        dars_pkg::t_req      r;
        dars_pkg::t_req      p;
        int                  k;
        res = '0;
        res.status = dars_pkg::ST_OK;
        r = {it.tag, it.track, it.first_sector, it.sector_count, it.platter, it.is_write};
        case (it.op)
            dars_pkg::OP_ENQ: begin
                if (!fits_disk(r)) begin
                    res.status = dars_pkg::ST_INVALID;
                    o_refused++;
                end else if (queued_reqs.size() >= QUEUE_DEPTH) begin
                    res.status = dars_pkg::ST_FULL;
                    o_refused++;
                end else begin
                    queued_reqs.push_back(r);
                end
            end
            dars_pkg::OP_PICK: begin
                if (queued_reqs.size() == 0) begin
                    res.status = dars_pkg::ST_EMPTY;
                    o_empty_picks++;
                end else begin
                    k = choose_slot();
                    p = queued_reqs[k];
                    queued_reqs.delete(k);
                    res.out_tag          = p.tag;
                    res.out_track        = p.track;
                    res.out_first_sector = p.first_sector;
                    res.out_sector_count = p.sector_count;
                    res.out_platter      = p.platter;
                    res.out_is_write     = p.is_write;
                    arm_pos              = p.track;
                    o_picked++;
                end
            end
            dars_pkg::OP_ARM: arm_pos = it.track;
            default: res.status = dars_pkg::ST_INVALID;
        endcase
        res.arm_position = arm_pos;
        return res;
    endfunction

    task automatic show_item(input string label, input dars_pkg::t_out_item o);
        $display("%0t: %s st=%0d tag=%0d trk=%0d fs=%0d sc=%0d pl=%0d wr=%0d arm=%0d",
                 $realtime, label, o.status, o.out_tag, o.out_track, o.out_first_sector,
                 o.out_sector_count, o.out_platter, o.out_is_write, o.arm_position);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            queued_reqs.delete();
            due_results.delete();
            arm_pos       = '0;
            rule_mode     = dars_pkg::MODE_RST;
            disk_tracks   = dars_pkg::TRACK_COUNT_RST;
            disk_platters = dars_pkg::PLATTER_COUNT_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dars_pkg::CFG_MODE:          rule_mode     = i_cfg_data[0];
                    dars_pkg::CFG_TRACK_COUNT:   disk_tracks   = i_cfg_data[15:0];
                    dars_pkg::CFG_PLATTER_COUNT: disk_platters = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                due_results.push_back(apply_item(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        show_item("result with no item pending:", i_out_item);
                end else begin
                    want = due_results.pop_front();
                    bad  = (i_out_item.status           !== want.status)           ||
                           (i_out_item.out_tag          !== want.out_tag)          ||
                           (i_out_item.out_track        !== want.out_track)        ||
                           (i_out_item.out_first_sector !== want.out_first_sector) ||
                           (i_out_item.out_sector_count !== want.out_sector_count) ||
                           (i_out_item.out_platter      !== want.out_platter)      ||
                           (i_out_item.out_is_write     !== want.out_is_write)     ||
                           (i_out_item.arm_position     !== want.arm_position);
                    if (bad) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            show_item("mismatch, wanted", want);
                            show_item("mismatch, got   ", i_out_item);
                        end
                    end
                end
            end
        end
        o_outstanding = due_results.size();
    end

endmodule

// ===== tb/tb_disk_arm_request_scheduler_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the disk arm request scheduler: clock, reset, register writes,
// directed and random request traffic, output back-pressure and the verdict.
// Depends on dars_pkg, disk_arm_request_scheduler_top and dars_sched_checker.

module tb_disk_arm_request_scheduler_top;

    localparam int         SPT          = dars_pkg::SECTORS_PER_TRACK_DEF;
    localparam int         LIMIT_CYCLES = 1_000_000;
    localparam int         LONG_HOLD    = 400;
    localparam int         DRAIN_CYCLES = 48;
    localparam int         PHASE_ITEMS  = 235;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic       MODE_SSTF    = 1'b1;
    localparam logic [1:0] ENQ          = dars_pkg::OP_ENQ;
    localparam logic [1:0] PICK         = dars_pkg::OP_PICK;
    localparam logic [1:0] SEEK         = dars_pkg::OP_ARM;
    localparam logic       RD           = dars_pkg::DIR_READ;
    localparam logic       WR           = dars_pkg::DIR_WRITE;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    dars_pkg::t_in_item              in_item;
    logic                            out_valid;
    logic                            out_stall;
    dars_pkg::t_out_item             out_item;
    logic                            cfg_we;
    logic [dars_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [dars_pkg::CFG_DATA_W-1:0] cfg_data;

    int   fail_count;
    int   outstanding;
    int   n_picked;
    int   n_refused;
    int   n_empty;
    int   n_sent;
    int   cycle_count;
    int   hold_reqs;

    // current geometry and the locality used to build seek-heavy traffic
    int          cur_tracks;
    int          cur_platters;
    int          focus;
    logic [15:0] last_trk;
    logic [7:0]  last_fs;

    disk_arm_request_scheduler_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    dars_sched_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_picked      (n_picked),
        .o_refused     (n_refused),
        .o_empty_picks (n_empty)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
        $display("FAILURE");
        $finish;
    end

    // output side: random stalls, calm stretches, and a long hold on request
    initial begin
        int stall_left;
        int cyc;
        int r;
        int holds_done;
        out_stall  = 1'b0;
        stall_left = 0;
        cyc        = 0;
        holds_done = 0;
        forever begin
            @(negedge clk);
            cyc++;
            if (hold_reqs != holds_done) begin
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                holds_done++;
            end else if (stall_left > 0) begin
                out_stall = 1'b1;
                stall_left--;
            end else begin
                out_stall = 1'b0;
                r = $urandom_range(0, 99);
                if ((cyc % 3000) >= 500) begin
                    if (r >= 95)
                        stall_left = $urandom_range(6, 40);
                    else if (r >= 72)
                        stall_left = $urandom_range(1, 3);
                end
            end
        end
    end

    // holds the item until it is taken; valid stays high into the next call
    task automatic send(input dars_pkg::t_in_item it);
        @(negedge clk);
        in_valid = 1'b1;
        in_item  = it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_sent++;
    endtask

    task automatic send_req(input logic [1:0] op, input int tag, input int trk, input int fs,
                            input int sc, input int plt, input logic wr);
        dars_pkg::t_in_item it;
        it.op           = op;
        it.tag          = tag[7:0];
        it.track        = trk[15:0];
        it.first_sector = fs[7:0];
        it.sector_count = sc[15:0];
        it.platter      = plt[7:0];
        it.is_write     = wr;
        send(it);
    endtask

    task automatic idle(input int n);
        repeat (n) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [dars_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value[dars_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly well-formed items: picks, seeks, unused ops, and enqueues near a moving focus
    // track, at the last target or anywhere; plus near-miss invalid ones and raw noise
    function automatic dars_pkg::t_in_item random_item(input int enq_pct);
        dars_pkg::t_in_item it;
        logic [63:0]        raw;
        int                 r;
        int                 d;
        int                 t;
        int                 room;
        int                 cap;
        raw = {$urandom(), $urandom()};
        it  = raw[$bits(dars_pkg::t_in_item)-1:0];
        r   = $urandom_range(0, 99);
        if (r >= enq_pct) begin
            r = $urandom_range(0, 99);
            if (r < 84) begin
                it.op = PICK;
            end else if (r < 96) begin
                it.op = SEEK;
                if ($urandom_range(0, 4) != 0)
                    it.track = 16'($urandom_range(0, cur_tracks - 1));
            end else begin
                it.op = OP_UNUSED;
            end
            return it;
        end
        it.op = ENQ;
        if ($urandom_range(0, 99) < 8) return it;
        it.platter = 8'($urandom_range(0, cur_platters - 1));
        r = $urandom_range(0, 99);
        if (r < 40) begin
            d = $urandom_range(0, 8);
            t = focus + d - 4;
            if (t < 0) t = 0;
            if (t >= cur_tracks) t = cur_tracks - 1;
            it.track        = t[15:0];
            it.first_sector = 8'($urandom_range(0, SPT - 1));
        end else if (r < 55 && last_trk < cur_tracks) begin
            it.track        = last_trk;
            it.first_sector = last_fs;
        end else begin
            it.track        = 16'($urandom_range(0, cur_tracks - 1));
            it.first_sector = 8'($urandom_range(0, SPT - 1));
        end
        last_trk = it.track;
        last_fs  = it.first_sector;
        room = (cur_tracks - int'(it.track)) * SPT - int'(it.first_sector);
        if (room > 65535) room = 65535;
        cap = (room < 24) ? room : 24;
        r = $urandom_range(0, 99);
        if (r < 10)
            it.sector_count = room[15:0];
        else if (r < 25)
            it.sector_count = 16'($urandom_range(1, room));
        else
            it.sector_count = 16'($urandom_range(1, cap));
        r = $urandom_range(0, 99);
        if (r < 4)
            it.sector_count = '0;
        else if (r < 8)
            it.sector_count = 16'(room + 1);     // one sector past the end of the disk
        else if (r < 11)
            it.first_sector = 8'($urandom_range(SPT, 255));
        else if (r < 14)
            it.platter = 8'($urandom_range(cur_platters, 255));
        else if (r < 16)
            it.track = 16'($urandom_range(cur_tracks, 65535));
        return it;
    endfunction

    task automatic run_phase(input logic mode, input int tracks, input int platters,
                             input bit hold);
        int sent;
        int burst_left;
        int enq_pct;
        bit calm;
        drain();
        write_reg(dars_pkg::CFG_MODE, int'(mode));
        write_reg(dars_pkg::CFG_TRACK_COUNT, tracks);
        write_reg(dars_pkg::CFG_PLATTER_COUNT, platters);
        cur_tracks   = tracks;
        cur_platters = platters;
        focus        = $urandom_range(0, tracks - 1);
        if (hold) hold_reqs++;
        sent       = 0;
        burst_left = 0;
        enq_pct    = 50;
        calm       = 1'b0;
        while (sent < PHASE_ITEMS) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(15, 60);
                case ($urandom_range(0, 3))
                    0: enq_pct = 30;
                    1: enq_pct = 50;
                    2: enq_pct = 65;
                    default: enq_pct = 85;
                endcase
                calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 2) == 0) focus = $urandom_range(0, tracks - 1);
            end
            // sender also waits out every pending result halfway through each setting
            if (sent == PHASE_ITEMS / 2) drain();
            send(random_item(enq_pct));
            sent++;
            burst_left--;
            if (!calm) idle(gap_len());
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        cfg_we        = 1'b0;
        cfg_idx       = dars_pkg::CFG_MODE;
        cfg_data      = '0;
        hold_reqs     = 0;
        n_sent        = 0;
        last_trk      = '0;
        last_fs       = '0;
        cur_tracks    = int'(dars_pkg::TRACK_COUNT_RST);
        cur_platters  = int'(dars_pkg::PLATTER_COUNT_RST);
        focus         = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, reset geometry: 256 tracks, one platter, SSTF
        send_req(PICK,        0,     0,   0,     0,   0, RD);   // empty queue
        send_req(OP_UNUSED,   9,     5,   1,     1,   0, RD);
        send_req(ENQ,         5,    10,   0,     1,   1, RD);   // platter out of range
        send_req(ENQ,         5,   256,   0,     1,   0, RD);   // track out of range
        send_req(ENQ,         5,    10,  16,     1,   0, RD);   // sector out of range
        send_req(ENQ,         5,    10,   0,     0,   0, RD);   // zero sectors
        send_req(ENQ,         5,   255,  15,     2,   0, RD);   // run past the last sector
        send_req(ENQ,       255,   255,  15,     1,   0, WR);   // exactly the last sector
        send_req(ENQ,         0,     0,   0,  4096,   0, RD);   // whole disk
        send_req(ENQ,        77, 65535, 255, 65535, 255, WR);
        send_req(SEEK,        0, 65535,   0,     0,   0, RD);
        send_req(SEEK,        0,   100,   0,     0,   0, RD);
        send_req(ENQ,         1,    90,   3,     8,   0, RD);
        send_req(ENQ,         3,    90,   3,     8,   0, WR);   // same target, write wins
        send_req(ENQ,         4,    90,   3,     8,   0, RD);   // same target, read loses
        send_req(ENQ,         2,   110,   0,    20,   0, RD);   // equal distance, later wins
        repeat (7) send_req(PICK, 0, 0, 0, 0, 0, RD);          // last one finds it empty

        run_phase(dars_pkg::MODE_FCFS,   256,   1, 1'b1);
        run_phase(MODE_SSTF,           65535, 255, 1'b0);
        run_phase(dars_pkg::MODE_FCFS, 65535, 255, 1'b0);
        run_phase(MODE_SSTF,               1,   1, 1'b0);
        run_phase(dars_pkg::MODE_FCFS,     1, 255, 1'b1);
        run_phase(MODE_SSTF,              40,   4, 1'b0);
        run_phase(dars_pkg::MODE_FCFS,     7,   2, 1'b0);
        run_phase(MODE_SSTF, $urandom_range(1, 65535), $urandom_range(1, 255), 1'b0);

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Ran %0d items over eight disk geometries, both pick rules, long holds.",
                 n_sent);
        $display("Requests served %0d, refused %0d, empty picks %0d, mismatches %0d.",
                 n_picked, n_refused, n_empty, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
src/dars_pkg.sv
src/disk_arm_request_scheduler_top.sv
tb/dars_sched_checker.sv
tb/tb_disk_arm_request_scheduler_top.sv
